// File: rtl/gsa_pkg.sv
// gsa_pkg: item types, status codes and fixed constants of the subframe assembler
// used by the channel interfaces, the store modules and the top level
`timescale 1ns / 1ps

package gsa_pkg;

    localparam int unsigned FIRST_SAT = 1;
    localparam int unsigned WORD_W    = 30;
    localparam int unsigned ROW_WORDS = 9;      // stored words 1..9 of a subframe
    localparam int unsigned SAT_IDX_W = 6;

    localparam logic [7:0]  L1CA_PREAMBLE = 8'h8B;
    localparam logic [16:0] TOW_LIMIT     = 17'd100800;
    localparam logic [19:0] WEEK_LAST_TOT = 20'd604794;

    localparam logic [2:0] ST_BAD_SIZE  = 3'd0;
    localparam logic [2:0] ST_NOT_L1CA  = 3'd1;
    localparam logic [2:0] ST_BAD_ID    = 3'd2;
    localparam logic [2:0] ST_STORED    = 3'd3;
    localparam logic [2:0] ST_IOD_MISS  = 3'd4;
    localparam logic [2:0] ST_BAD_TOW   = 3'd5;
    localparam logic [2:0] ST_WORD      = 3'd6;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [ROW_WORDS-1:0][WORD_W-1:0] t_row;

    typedef struct packed {
        logic [5:0] prn;
        logic [3:0] word_count;
        t_word      word_0;
        t_word      word_1;
        t_word      word_2;
        t_word      word_3;
        t_word      word_4;
        t_word      word_5;
        t_word      word_6;
        t_word      word_7;
        t_word      word_8;
        t_word      word_9;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  sat_id;
        logic [1:0]  frame_part;
        logic [2:0]  word_slot;
        t_word       data_word;
        logic [19:0] transmit_tow;
        logic        last_of_run;
    } t_out_item;

    // write request to the valid-bit store
    typedef struct packed {
        logic                 we;
        logic [SAT_IDX_W-1:0] sat;
        logic [2:0]           bits;
    } t_vs_wr;

endpackage

// File: rtl/gsa_channels.sv
// gsa_channels: valid/ready channel interfaces for input subframes and result items
// depends on gsa_pkg for the item types
`timescale 1ns / 1ps

interface gsa_in_if import gsa_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gsa_out_if import gsa_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/gps_subframe_assembler.sv
// channel   dir  handshake        payload
// i_item    in   valid & ready    prn, word_count, word_0 .. word_9
// o_result  out  valid & ready    status, sat_id, frame_part, word_slot, data_word,
//                                 transmit_tow, last_of_run
//
// a rejected or only stored item: accept in S_IDLE, then check and write in S_CHK
// a completed set reads rows 1, 2, 0 in S_RD1, S_RD2, S_RD0, one row read per cycle
// from the subframe memory, then 24 results, one per cycle into the output register
// reset is synchronous; the valid store reads zero for unwritten entries, no clear pass
// a stalled o_result holds the sequencer; the next item is taken while a result waits
// gps_subframe_assembler: sequencer over the valid store and the subframe memory
// depends on gsa_pkg, gsa_channels, gsa_valid_store, gsa_frame_store
`timescale 1ns / 1ps

module gps_subframe_assembler import gsa_pkg::*; #(
    parameter int unsigned NUM_SATS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gsa_in_if.sink     i_item,
    gsa_out_if.source  o_result
);

    localparam int unsigned SAT_W  = (NUM_SATS > 1) ? $clog2(NUM_SATS) : 1;
    localparam int unsigned ROW_AW = $clog2(NUM_SATS * 3);
    localparam logic [6:0]  SAT_END = 7'(FIRST_SAT + NUM_SATS);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CHK  = 7'b0000010,
        S_RD1  = 7'b0000100,
        S_RD2  = 7'b0001000,
        S_RD0  = 7'b0010000,
        S_EVAL = 7'b0100000,
        S_EMIT = 7'b1000000
    } t_state;

    t_state      r_state, n_state;
    t_in_item    r_in, n_in;
    logic [2:0]  r_nv, n_nv;
    logic [7:0]  r_iod1, n_iod1;
    logic [7:0]  r_iod2, n_iod2;
    logic [19:0] r_tot, n_tot;
    logic [1:0]  r_part, n_part;
    logic [2:0]  r_slot, n_slot;
    t_out_item   r_out, n_out;
    logic        r_out_valid, n_out_valid;

    logic                 vs_rd_en;
    logic [SAT_IDX_W-1:0] vs_rd_sat;
    t_vs_wr               vs_wr;
    logic [2:0]           valid_bits;

    logic              fs_we;
    logic [ROW_AW-1:0] fs_wr_addr;
    t_row              fs_wr_row;
    logic              fs_rd_en;
    logic [ROW_AW-1:0] fs_rd_addr;
    t_row              rd_row;

    logic       out_free;
    logic [5:0] in_m1, cur_m1;
    logic [SAT_W-1:0] cur_sat;
    logic       bad_size, bad_pre, bad_id;
    logic [2:0] sf_id;
    logic [1:0] sf;
    logic [2:0] sf_bit;
    logic [2:0] nv;
    logic [7:0] iod0;
    logic [16:0] tow6;
    logic [19:0] tow_m1;
    logic [19:0] tot;

    function automatic logic [ROW_AW-1:0] row_addr(input logic [SAT_W-1:0] s,
                                                   input logic [1:0] p);
        row_addr = ROW_AW'({s, 1'b0}) + ROW_AW'(s) + ROW_AW'(p);
    endfunction

    function automatic t_out_item status_item(input logic [2:0] st, input logic [5:0] prn);
        t_out_item it;
        it              = '0;
        it.status       = st;
        it.sat_id       = prn;
        it.last_of_run  = 1'b1;
        return it;
    endfunction

    gsa_valid_store #(
        .NUM_SATS (NUM_SATS)
    ) u_valid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (vs_rd_en),
        .i_rd_sat (vs_rd_sat),
        .i_wr     (vs_wr),
        .o_bits   (valid_bits)
    );

    gsa_frame_store #(
        .NUM_SATS (NUM_SATS)
    ) u_frames (
        .i_clk     (i_clk),
        .i_we      (fs_we),
        .i_wr_addr (fs_wr_addr),
        .i_wr_row  (fs_wr_row),
        .i_rd_en   (fs_rd_en),
        .i_rd_addr (fs_rd_addr),
        .o_rd_row  (rd_row)
    );

    assign i_item.ready  = (r_state == S_IDLE);
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;
    assign out_free = !r_out_valid || o_result.ready;

    // checks on the held item
    assign in_m1    = i_item.data.prn - 6'(FIRST_SAT);
    assign cur_m1   = r_in.prn - 6'(FIRST_SAT);
    assign cur_sat  = cur_m1[SAT_W-1:0];
    assign bad_size = ({1'b0, r_in.prn} < 7'(FIRST_SAT)) || ({1'b0, r_in.prn} >= SAT_END)
                      || (r_in.word_count != 4'd10);
    assign bad_pre  = (r_in.word_0[29:22] != L1CA_PREAMBLE);
    assign sf_id    = r_in.word_1[10:8];
    assign bad_id   = (sf_id == 3'd0) || (sf_id > 3'd3);
    assign sf       = sf_id[1:0] - 2'd1;
    assign sf_bit   = 3'b001 << sf;
    assign nv       = valid_bits | sf_bit;

    // row 0 sits in the read register during S_EVAL
    assign iod0   = rd_row[6][29:22];
    assign tow6   = rd_row[0][29:13];
    assign tow_m1 = 20'(tow6) - 20'd1;
    assign tot    = (tow6 == 17'd0) ? WEEK_LAST_TOT : ((tow_m1 << 2) + (tow_m1 << 1));

    always_comb begin
        fs_wr_row[0] = r_in.word_1;
        fs_wr_row[1] = r_in.word_2;
        fs_wr_row[2] = r_in.word_3;
        fs_wr_row[3] = r_in.word_4;
        fs_wr_row[4] = r_in.word_5;
        fs_wr_row[5] = r_in.word_6;
        fs_wr_row[6] = r_in.word_7;
        fs_wr_row[7] = r_in.word_8;
        fs_wr_row[8] = r_in.word_9;
    end

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_nv        = r_nv;
        n_iod1      = r_iod1;
        n_iod2      = r_iod2;
        n_tot       = r_tot;
        n_part      = r_part;
        n_slot      = r_slot;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_result.ready;

        vs_rd_en   = 1'b0;
        vs_rd_sat  = '0;
        vs_wr      = '0;
        vs_wr.sat  = SAT_IDX_W'(cur_sat);
        fs_we      = 1'b0;
        fs_wr_addr = row_addr(cur_sat, sf);
        fs_rd_en   = 1'b0;
        fs_rd_addr = row_addr(cur_sat, 2'd0);

        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_in     = i_item.data;
                    vs_rd_en = 1'b1;
                    if (({1'b0, i_item.data.prn} >= 7'(FIRST_SAT)) &&
                        ({1'b0, i_item.data.prn} < SAT_END)) begin
                        vs_rd_sat = SAT_IDX_W'(in_m1[SAT_W-1:0]);
                    end
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (out_free) begin
                    if (bad_size) begin
                        n_out       = status_item(ST_BAD_SIZE, r_in.prn);
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else if (bad_pre) begin
                        n_out       = status_item(ST_NOT_L1CA, r_in.prn);
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else if (bad_id) begin
                        n_out       = status_item(ST_BAD_ID, r_in.prn);
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        fs_we = 1'b1;
                        n_nv  = nv;
                        if (nv != 3'b111) begin
                            vs_wr.we    = 1'b1;
                            vs_wr.bits  = nv;
                            n_out       = status_item(ST_STORED, r_in.prn);
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                        end else begin
                            n_state = S_RD1;
                        end
                    end
                end
            end
            S_RD1: begin
                // reads start after the row write so the new subframe is seen
                fs_rd_en   = 1'b1;
                fs_rd_addr = row_addr(cur_sat, 2'd1);
                n_state    = S_RD2;
            end
            S_RD2: begin
                fs_rd_en   = 1'b1;
                fs_rd_addr = row_addr(cur_sat, 2'd2);
                n_iod1     = rd_row[1][29:22];
                n_state    = S_RD0;
            end
            S_RD0: begin
                fs_rd_en   = 1'b1;
                fs_rd_addr = row_addr(cur_sat, 2'd0);
                n_iod2     = rd_row[8][29:22];
                n_state    = S_EVAL;
            end
            S_EVAL: begin
                if (out_free) begin
                    if ((iod0 != r_iod1) || (r_iod1 != r_iod2)) begin
                        vs_wr.we    = 1'b1;
                        vs_wr.bits  = r_nv & sf_bit;
                        n_out       = status_item(ST_IOD_MISS, r_in.prn);
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else if (tow6 >= TOW_LIMIT) begin
                        vs_wr.we    = 1'b1;
                        vs_wr.bits  = r_nv & 3'b110;
                        n_out       = status_item(ST_BAD_TOW, r_in.prn);
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_tot   = tot;
                        n_part  = 2'd0;
                        n_slot  = 3'd0;
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out.status       = ST_WORD;
                    n_out.sat_id       = r_in.prn;
                    n_out.frame_part   = r_part;
                    n_out.word_slot    = r_slot;
                    n_out.data_word    = rd_row[{1'b0, r_slot} + 4'd1];
                    n_out.transmit_tow = r_tot;
                    n_out.last_of_run  = (r_part == 2'd2) && (r_slot == 3'd7);
                    n_out_valid        = 1'b1;
                    n_slot             = r_slot + 3'd1;
                    if (r_slot == 3'd7) begin
                        if (r_part == 2'd2) begin
                            vs_wr.we   = 1'b1;
                            vs_wr.bits = 3'b000;
                            n_state    = S_IDLE;
                        end else begin
                            // next row lands in the read register for the next cycle
                            fs_rd_en   = 1'b1;
                            fs_rd_addr = row_addr(cur_sat, r_part + 2'd1);
                            n_part     = r_part + 2'd1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_part      <= 2'd0;
            r_slot      <= 3'd0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_part      <= n_part;
            r_slot      <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_nv   <= n_nv;
        r_iod1 <= n_iod1;
        r_iod2 <= n_iod2;
        r_tot  <= n_tot;
        r_out  <= n_out;
    end

    a_last_word_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.data.status == ST_WORD && o_result.data.last_of_run)
        |-> (o_result.data.frame_part == 2'd2 && o_result.data.word_slot == 3'd7))
        else $error("last word of a run not at part 2 slot 7");

    a_emit_full_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_nv == 3'b111))
        else $error("emitting without a complete subframe set");

    a_chk_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> ($past(r_state) == S_IDLE || $past(r_state) == S_CHK))
        else $error("check state entered without an accepted item");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.data.status != ST_WORD) |-> o_result.data.last_of_run)
        else $error("status item without last_of_run");

endmodule

// File: rtl/gsa_valid_store.sv
// gsa_valid_store: per-satellite 3-bit subframe valid memory, registered read
// entries never written since reset read as zero; depends on gsa_pkg
`timescale 1ns / 1ps

module gsa_valid_store import gsa_pkg::*; #(
    parameter int unsigned NUM_SATS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [SAT_IDX_W-1:0]       i_rd_sat,
    input  t_vs_wr                     i_wr,
    output logic [2:0]                 o_bits
);

    localparam int unsigned SAT_W = (NUM_SATS > 1) ? $clog2(NUM_SATS) : 1;

    logic [2:0]          r_mem [NUM_SATS];
    logic [NUM_SATS-1:0] r_written;
    logic [2:0]          r_rd;
    logic                r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.sat[SAT_W-1:0]] <= i_wr.bits;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_sat[SAT_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_ok   <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_written[i_wr.sat[SAT_W-1:0]] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_written[i_rd_sat[SAT_W-1:0]];
            end
        end
    end

    assign o_bits = r_rd_ok ? r_rd : 3'b000;

endmodule

// File: rtl/gsa_frame_store.sv
// gsa_frame_store: subframe memory, one row of words 1..9 per satellite and subframe
// one write and one registered read per cycle; depends on gsa_pkg
`timescale 1ns / 1ps

module gsa_frame_store import gsa_pkg::*; #(
    parameter int unsigned NUM_SATS = 32,
    localparam int unsigned DEPTH   = NUM_SATS * 3,
    localparam int unsigned AW      = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wr_addr,
    input  t_row          i_wr_row,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_row          o_rd_row
);

    t_row r_mem [DEPTH];
    t_row r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_row = r_rd;

endmodule
